>>> sv/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shorthand for clocked concurrent assertions that report through $error.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising edge while reset is released.
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Implication form of the above.
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
  `ASSERT_CLK(lbl, clk, rst_n, (ante) |-> (cons), msg)

`endif

>>> sv/lthc_pkg.sv
// ----------------------------------------------------------------------------
// lthc_pkg
// Shared constants, codes and types of the LRU/TTL hash cache.
// ----------------------------------------------------------------------------
package lthc_pkg;

  localparam int ENTRIES     = 256;
  localparam int IDX_W       = $clog2(ENTRIES);
  localparam int LINK_W      = IDX_W + 1;
  localparam int KEY_BYTES   = 8;
  localparam int KEY_W       = 64;
  localparam int LEN_W       = $clog2(KEY_BYTES + 1);
  localparam int BORROW_BITS = 16;
  localparam int TIME_BITS   = 32;
  localparam int HASH_W      = 64;
  localparam int VAL_W       = 32;
  localparam int CAP_W       = 9;
  localparam int TTL_W       = 31;
  localparam int CNT_W       = 32;
  localparam int FUNC_W      = 3;
  localparam int STAT_W      = 3;
  localparam int ADDR_W      = 3;
  localparam int DATA_W      = 32;
  localparam int QUEUE_DEPTH = 2;
  localparam int MOD_STEPS   = HASH_W / 2;
  localparam int MCNT_W      = $clog2(MOD_STEPS);
  localparam int REM_W       = IDX_W + 3;

  localparam logic [LINK_W-1:0] NIL_LINK  = LINK_W'(ENTRIES);
  localparam logic [HASH_W-1:0] HASH_SEED = HASH_W'(5381);
  localparam logic [CAP_W-1:0]  CAP_RESET = CAP_W'(256);
  localparam logic [TTL_W-1:0]  TTL_RESET = TTL_W'(300);

  localparam logic [FUNC_W-1:0] FN_GET     = 3'd0;
  localparam logic [FUNC_W-1:0] FN_PUT     = 3'd1;
  localparam logic [FUNC_W-1:0] FN_RELEASE = 3'd2;
  localparam logic [FUNC_W-1:0] FN_INVAL   = 3'd3;
  localparam logic [FUNC_W-1:0] FN_CLEAR   = 3'd4;

  localparam logic [STAT_W-1:0] ST_OK      = 3'd0;
  localparam logic [STAT_W-1:0] ST_MISS    = 3'd1;
  localparam logic [STAT_W-1:0] ST_EXPIRED = 3'd2;
  localparam logic [STAT_W-1:0] ST_DROPPED = 3'd3;
  localparam logic [STAT_W-1:0] ST_IGNORED = 3'd4;

  localparam logic REG_CAPACITY = 1'b0;
  localparam logic REG_TTL      = 1'b1;

  typedef struct packed {
    logic [FUNC_W-1:0]    func;
    logic [KEY_W-1:0]     key;
    logic [LEN_W-1:0]     len;
    logic [VAL_W-1:0]     handle;
    logic [IDX_W-1:0]     rslot;
    logic [TIME_BITS-1:0] now;
    logic [IDX_W-1:0]     start;
  } item_t;

  function automatic logic [CAP_W-1:0] eff_cap(input logic [CAP_W-1:0] c);
    logic [CAP_W-1:0] r;
    r = c;
    if (c == '0) r = CAP_W'(1);
    else if (c > CAP_W'(ENTRIES)) r = CAP_W'(ENTRIES);
    return r;
  endfunction

endpackage

>>> sv/lthc_queue.sv
// ----------------------------------------------------------------------------
// lthc_queue
// Small FIFO of classified items between the front and the back part.
// ----------------------------------------------------------------------------
module lthc_queue (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push_valid,
  output logic                 push_ready,
  input  lthc_pkg::item_t      push_item,
  output logic                 pop_valid,
  input  logic                 pop_ready,
  output lthc_pkg::item_t      pop_item
);

  localparam int PTR_W = $clog2(lthc_pkg::QUEUE_DEPTH);
  localparam int CNT_W = $clog2(lthc_pkg::QUEUE_DEPTH + 1);

  lthc_pkg::item_t   slot_r [lthc_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0]  wptr_r;
  logic [PTR_W-1:0]  rptr_r;
  logic [CNT_W-1:0]  cnt_r;
  logic              do_push;
  logic              do_pop;

  assign push_ready = (cnt_r != CNT_W'(lthc_pkg::QUEUE_DEPTH));
  assign pop_valid  = (cnt_r != '0);
  assign pop_item   = slot_r[rptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // Depth is a power of two, so the pointers wrap on their own.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      if (do_push) begin
        slot_r[wptr_r] <= push_item;
        wptr_r         <= wptr_r + 1'b1;
      end
      if (do_pop) rptr_r <= rptr_r + 1'b1;
      if (do_push && !do_pop) cnt_r <= cnt_r + 1'b1;
      else if (!do_push && do_pop) cnt_r <= cnt_r - 1'b1;
    end
  end

endmodule

>>> sv/lthc_front.sv
// ----------------------------------------------------------------------------
// lthc_front
// Accepts items, trims keys at the first zero byte, hashes them one byte a
// cycle and reduces the hash modulo the capacity two bits a cycle.
// ----------------------------------------------------------------------------
module lthc_front (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [lthc_pkg::FUNC_W-1:0]          in_func,
  input  logic [lthc_pkg::KEY_W-1:0]           in_lookup_key,
  input  logic [lthc_pkg::VAL_W-1:0]           in_value_handle,
  input  logic [lthc_pkg::IDX_W-1:0]           in_release_slot,
  input  logic [lthc_pkg::TIME_BITS-1:0]       in_now_s,
  input  logic [lthc_pkg::CAP_W-1:0]           cap,
  output logic                                 q_valid,
  input  logic                                 q_ready,
  output lthc_pkg::item_t                      q_item
);

  localparam logic [1:0] F_IDLE = 2'd0;
  localparam logic [1:0] F_HASH = 2'd1;
  localparam logic [1:0] F_MOD  = 2'd2;
  localparam logic [1:0] F_PUSH = 2'd3;

  logic [1:0]                        state_r;
  lthc_pkg::item_t                   item_r;
  logic [lthc_pkg::HASH_W-1:0]       hash_r;
  logic [lthc_pkg::KEY_W-1:0]        shk_r;
  logic [lthc_pkg::LEN_W-1:0]        bcnt_r;
  logic [lthc_pkg::MCNT_W-1:0]       mcnt_r;
  logic [lthc_pkg::IDX_W-1:0]        rem_r;

  logic [lthc_pkg::KEY_W-1:0]        nkey;
  logic [lthc_pkg::LEN_W-1:0]        nlen;
  logic                              stop;
  logic [lthc_pkg::HASH_W-1:0]       hash_step;
  logic [lthc_pkg::REM_W-1:0]        r4;
  logic [lthc_pkg::REM_W-1:0]        c1;
  logic [lthc_pkg::REM_W-1:0]        c2;
  logic [lthc_pkg::REM_W-1:0]        c3;
  logic [lthc_pkg::REM_W-1:0]        r4_red;
  logic [lthc_pkg::IDX_W-1:0]        rem_nxt;

  assign in_ready = (state_r == F_IDLE);
  assign q_valid  = (state_r == F_PUSH);
  assign q_item   = item_r;

  // Key bytes after the first zero byte do not belong to the key.
  always_comb begin
    nkey = '0;
    nlen = '0;
    stop = 1'b0;
    for (int i = 0; i < lthc_pkg::KEY_BYTES; i++) begin
      if (!stop) begin
        if (in_lookup_key[lthc_pkg::KEY_W-1-8*i -: 8] == 8'd0) begin
          stop = 1'b1;
        end else begin
          nkey[lthc_pkg::KEY_W-1-8*i -: 8] = in_lookup_key[lthc_pkg::KEY_W-1-8*i -: 8];
          nlen = lthc_pkg::LEN_W'(i + 1);
        end
      end
    end
  end

  assign hash_step = (hash_r << 5) + hash_r
                   + lthc_pkg::HASH_W'(shk_r[lthc_pkg::KEY_W-1 -: 8]);

  // Remainder stays below cap, so after taking two more hash bits at most
  // three subtractions of cap are needed.
  assign r4 = {1'b0, rem_r, hash_r[lthc_pkg::HASH_W-1 -: 2]};
  assign c1 = lthc_pkg::REM_W'(cap);
  assign c2 = c1 << 1;
  assign c3 = c1 + c2;

  always_comb begin
    if (r4 >= c3) r4_red = r4 - c3;
    else if (r4 >= c2) r4_red = r4 - c2;
    else if (r4 >= c1) r4_red = r4 - c1;
    else r4_red = r4;
  end

  assign rem_nxt = r4_red[lthc_pkg::IDX_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
    end else begin
      unique case (state_r)
        F_IDLE: begin
          if (in_valid) begin
            item_r.func   <= in_func;
            item_r.key    <= nkey;
            item_r.len    <= nlen;
            item_r.handle <= in_value_handle;
            item_r.rslot  <= in_release_slot;
            item_r.now    <= in_now_s;
            item_r.start  <= '0;
            shk_r         <= nkey;
            hash_r        <= lthc_pkg::HASH_SEED;
            rem_r         <= '0;
            mcnt_r        <= '0;
            bcnt_r        <= '0;
            if (in_func == lthc_pkg::FN_GET || in_func == lthc_pkg::FN_PUT) begin
              state_r <= (nlen != '0) ? F_HASH : F_MOD;
            end else begin
              state_r <= F_PUSH;
            end
          end
        end
        F_HASH: begin
          hash_r <= hash_step;
          shk_r  <= shk_r << 8;
          bcnt_r <= bcnt_r + 1'b1;
          if (bcnt_r + 1'b1 == item_r.len) state_r <= F_MOD;
        end
        F_MOD: begin
          hash_r <= hash_r << 2;
          rem_r  <= rem_nxt;
          mcnt_r <= mcnt_r + 1'b1;
          if (mcnt_r == lthc_pkg::MCNT_W'(lthc_pkg::MOD_STEPS - 1)) begin
            item_r.start <= rem_nxt;
            state_r      <= F_PUSH;
          end
        end
        F_PUSH: begin
          if (q_ready) state_r <= F_IDLE;
        end
        default: state_r <= F_IDLE;
      endcase
    end
  end

endmodule

>>> sv/lthc_back.sv
// ----------------------------------------------------------------------------
// lthc_back
// Carries out one item at a time: probes the slot table, keeps the LRU
// list, ages and borrow counts, and holds the result in an output register.
// ----------------------------------------------------------------------------
module lthc_back (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic [lthc_pkg::CAP_W-1:0]        cap,
  input  logic [lthc_pkg::TTL_W-1:0]        ttl,
  input  logic                              q_valid,
  output logic                              q_ready,
  input  lthc_pkg::item_t                   q_item,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [lthc_pkg::STAT_W-1:0]       out_status,
  output logic [lthc_pkg::VAL_W-1:0]        out_found_value,
  output logic [lthc_pkg::IDX_W-1:0]        out_found_slot,
  output logic [lthc_pkg::CAP_W-1:0]        out_live_count,
  output logic [lthc_pkg::CNT_W-1:0]        out_hit_total,
  output logic [lthc_pkg::CNT_W-1:0]        out_miss_total,
  output logic [lthc_pkg::CNT_W-1:0]        out_eviction_total
);

  localparam int ENT   = lthc_pkg::ENTRIES;
  localparam int IW    = lthc_pkg::IDX_W;
  localparam int LW    = lthc_pkg::LINK_W;
  localparam int CW    = lthc_pkg::CAP_W;
  localparam int TW    = lthc_pkg::TIME_BITS;
  localparam int BW    = lthc_pkg::BORROW_BITS;
  localparam int VW    = lthc_pkg::VAL_W;
  localparam int KW    = lthc_pkg::KEY_W;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_PRB   = 4'd1;
  localparam logic [3:0] S_PCMP  = 4'd2;
  localparam logic [3:0] S_GCHK  = 4'd3;
  localparam logic [3:0] S_DET   = 4'd4;
  localparam logic [3:0] S_PF1   = 4'd5;
  localparam logic [3:0] S_PF2   = 4'd6;
  localparam logic [3:0] S_EVCHK = 4'd7;
  localparam logic [3:0] S_FREE  = 4'd8;
  localparam logic [3:0] S_REL2  = 4'd9;
  localparam logic [3:0] S_FIN   = 4'd10;

  // What follows the unlink step.
  localparam logic [1:0] ACT_MOVE   = 2'd0;
  localparam logic [1:0] ACT_RETIRE = 2'd1;
  localparam logic [1:0] ACT_EVICT  = 2'd2;
  localparam logic [1:0] ACT_NEW    = 2'd3;

  logic [3:0]              state_r;
  lthc_pkg::item_t         cur_r;
  logic [IW-1:0]           pos_r;
  logic [CW-1:0]           pcnt_r;
  logic [IW-1:0]           tgt_r;
  logic [1:0]              act_r;
  logic [lthc_pkg::STAT_W-1:0] status_r;
  logic [VW-1:0]           fval_r;
  logic [IW-1:0]           fslot_r;

  logic [ENT-1:0]          occ_r;
  logic [ENT-1:0]          del_r;
  logic [ENT-1:0]          bflag_r;   // borrow count above zero
  logic [ENT-1:0]          zflag_r;   // stamp reads as zero after invalidate
  logic [LW-1:0]           front_r;
  logic [LW-1:0]           back_r;
  logic [CW-1:0]           live_r;
  logic [lthc_pkg::CNT_W-1:0] hit_r;
  logic [lthc_pkg::CNT_W-1:0] miss_r;
  logic [lthc_pkg::CNT_W-1:0] evict_r;

  logic                    ov_r;
  logic [lthc_pkg::STAT_W-1:0] o_status_r;
  logic [VW-1:0]           o_fval_r;
  logic [IW-1:0]           o_fslot_r;
  logic [CW-1:0]           o_live_r;
  logic [lthc_pkg::CNT_W-1:0] o_hit_r;
  logic [lthc_pkg::CNT_W-1:0] o_miss_r;
  logic [lthc_pkg::CNT_W-1:0] o_evict_r;

  logic [KW-1:0]           key_mem   [ENT];
  logic [VW-1:0]           val_mem   [ENT];
  logic [TW-1:0]           stamp_mem [ENT];
  logic [BW-1:0]           bor_mem   [ENT];
  logic [LW-1:0]           prev_mem  [ENT];
  logic [LW-1:0]           next_mem  [ENT];
  logic [KW-1:0]           key_q;
  logic [VW-1:0]           val_q;
  logic [TW-1:0]           stamp_q;
  logic [BW-1:0]           bor_q;
  logic [LW-1:0]           prev_q;
  logic [LW-1:0]           next_q;

  logic                    rd_en;
  logic [IW-1:0]           rd_addr;
  logic [IW-1:0]           slot_wa;
  logic                    key_we;
  logic                    val_we;
  logic                    stamp_we;
  logic                    bor_we;
  logic [VW-1:0]           val_wd;
  logic [BW-1:0]           bor_wd;
  logic                    prev_we;
  logic [IW-1:0]           prev_wa;
  logic [LW-1:0]           prev_wd;
  logic                    next_we;
  logic [IW-1:0]           next_wa;
  logic [LW-1:0]           next_wd;

  logic                    live_at;
  logic                    empty_at;
  logic                    key_hit;
  logic                    last_probe;
  logic [IW-1:0]           pos_next;
  logic [TW-1:0]           stamp_eff;
  logic [TW-1:0]           age;
  logic                    expired;
  logic [BW-1:0]           bor_inc;
  logic [BW-1:0]           bor_dec;
  logic                    prev_ok;
  logic                    next_ok;
  logic                    front_ok;
  logic                    rel_ok;

  assign q_ready = (state_r == S_IDLE);

  assign live_at    = occ_r[pos_r] && !del_r[pos_r];
  assign empty_at   = !occ_r[pos_r] && !del_r[pos_r];
  assign key_hit    = live_at && (key_q == cur_r.key);
  assign last_probe = (pcnt_r + 1'b1 == cap);
  assign pos_next   = (CW'(pos_r) + 1'b1 == cap) ? '0 : pos_r + 1'b1;
  assign stamp_eff  = zflag_r[tgt_r] ? '0 : stamp_q;
  assign age        = cur_r.now - stamp_eff;
  assign expired    = age > TW'(ttl);
  assign bor_inc    = (bor_q == '1) ? bor_q : bor_q + 1'b1;
  assign bor_dec    = bor_q - 1'b1;
  assign prev_ok    = !prev_q[LW-1];
  assign next_ok    = !next_q[LW-1];
  assign front_ok   = !front_r[LW-1];
  assign rel_ok     = (CW'(q_item.rslot) < cap) && occ_r[q_item.rslot]
                   && bflag_r[q_item.rslot];

  // Memory port selection per step.
  always_comb begin
    rd_en    = 1'b0;
    rd_addr  = pos_r;
    slot_wa  = pos_r;
    key_we   = 1'b0;
    val_we   = 1'b0;
    stamp_we = 1'b0;
    bor_we   = 1'b0;
    val_wd   = cur_r.handle;
    bor_wd   = '0;
    prev_we  = 1'b0;
    prev_wa  = tgt_r;
    prev_wd  = lthc_pkg::NIL_LINK;
    next_we  = 1'b0;
    next_wa  = tgt_r;
    next_wd  = front_r;
    unique case (state_r)
      S_IDLE: begin
        rd_en   = 1'b1;
        rd_addr = q_item.rslot;
      end
      S_PRB: begin
        rd_en = 1'b1;
      end
      S_EVCHK: begin
        rd_en   = 1'b1;
        rd_addr = back_r[IW-1:0];
      end
      S_PCMP: begin
        if (key_hit && cur_r.func == lthc_pkg::FN_PUT) begin
          val_we   = 1'b1;
          stamp_we = 1'b1;
        end
      end
      S_GCHK: begin
        slot_wa = tgt_r;
        bor_wd  = bor_inc;
        bor_we  = !expired;
      end
      S_DET: begin
        next_we = prev_ok;
        next_wa = prev_q[IW-1:0];
        next_wd = next_q;
        prev_we = next_ok;
        prev_wa = next_q[IW-1:0];
        prev_wd = prev_q;
      end
      S_PF1: begin
        prev_we = 1'b1;
        next_we = 1'b1;
      end
      S_PF2: begin
        prev_we = front_ok;
        prev_wa = front_r[IW-1:0];
        prev_wd = LW'(tgt_r);
      end
      S_FREE: begin
        if (!occ_r[pos_r]) begin
          key_we   = 1'b1;
          val_we   = 1'b1;
          stamp_we = 1'b1;
          bor_we   = 1'b1;
        end
      end
      S_REL2: begin
        slot_wa = cur_r.rslot;
        bor_wd  = bor_dec;
        bor_we  = (val_q == cur_r.handle);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (key_we)   key_mem[slot_wa]   <= cur_r.key;
    if (val_we)   val_mem[slot_wa]   <= val_wd;
    if (stamp_we) stamp_mem[slot_wa] <= cur_r.now;
    if (bor_we)   bor_mem[slot_wa]   <= bor_wd;
    if (prev_we)  prev_mem[prev_wa]  <= prev_wd;
    if (next_we)  next_mem[next_wa]  <= next_wd;
    if (rd_en) begin
      key_q   <= key_mem[rd_addr];
      val_q   <= val_mem[rd_addr];
      stamp_q <= stamp_mem[rd_addr];
      bor_q   <= bor_mem[rd_addr];
      prev_q  <= prev_mem[rd_addr];
      next_q  <= next_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      occ_r   <= '0;
      del_r   <= '0;
      bflag_r <= '0;
      zflag_r <= '0;
      front_r <= lthc_pkg::NIL_LINK;
      back_r  <= lthc_pkg::NIL_LINK;
      live_r  <= '0;
      hit_r   <= '0;
      miss_r  <= '0;
      evict_r <= '0;
      ov_r    <= 1'b0;
    end else begin
      // The final step reloads the output register itself.
      if (ov_r && out_ready && state_r != S_FIN) ov_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (q_valid) begin
            cur_r   <= q_item;
            fval_r  <= '0;
            fslot_r <= '0;
            pos_r   <= q_item.start;
            pcnt_r  <= '0;
            status_r <= lthc_pkg::ST_OK;
            if (q_item.func == lthc_pkg::FN_GET ||
                (q_item.func == lthc_pkg::FN_PUT && q_item.len != '0)) begin
              state_r <= S_PRB;
            end else if (q_item.func == lthc_pkg::FN_RELEASE) begin
              if (rel_ok) begin
                state_r <= S_REL2;
              end else begin
                status_r <= lthc_pkg::ST_IGNORED;
                state_r  <= S_FIN;
              end
            end else if (q_item.func == lthc_pkg::FN_INVAL) begin
              zflag_r <= zflag_r | (occ_r & ~del_r);
              state_r <= S_FIN;
            end else if (q_item.func == lthc_pkg::FN_CLEAR) begin
              // Borrowed entries stay as pending deletes, all else is emptied.
              occ_r   <= occ_r & bflag_r;
              del_r   <= occ_r & bflag_r;
              live_r  <= '0;
              front_r <= lthc_pkg::NIL_LINK;
              back_r  <= lthc_pkg::NIL_LINK;
              state_r <= S_FIN;
            end else begin
              status_r <= lthc_pkg::ST_IGNORED;
              state_r  <= S_FIN;
            end
          end
        end
        S_PRB: state_r <= S_PCMP;
        S_PCMP: begin
          if (key_hit) begin
            tgt_r <= pos_r;
            if (cur_r.func == lthc_pkg::FN_GET) begin
              state_r <= S_GCHK;
            end else begin
              zflag_r[pos_r] <= 1'b0;
              act_r          <= ACT_MOVE;
              state_r        <= S_DET;
            end
          end else if (empty_at || last_probe) begin
            if (cur_r.func == lthc_pkg::FN_GET) begin
              miss_r   <= miss_r + 1'b1;
              status_r <= lthc_pkg::ST_MISS;
              state_r  <= S_FIN;
            end else begin
              state_r <= S_EVCHK;
            end
          end else begin
            pos_r   <= pos_next;
            pcnt_r  <= pcnt_r + 1'b1;
            state_r <= S_PRB;
          end
        end
        S_GCHK: begin
          if (expired) begin
            miss_r   <= miss_r + 1'b1;
            status_r <= lthc_pkg::ST_EXPIRED;
            act_r    <= ACT_RETIRE;
          end else begin
            hit_r          <= hit_r + 1'b1;
            bflag_r[tgt_r] <= 1'b1;
            fval_r         <= val_q;
            fslot_r        <= tgt_r;
            act_r          <= ACT_MOVE;
          end
          state_r <= S_DET;
        end
        S_DET: begin
          if (!prev_ok) front_r <= next_q;
          if (!next_ok) back_r  <= prev_q;
          if (act_r == ACT_RETIRE || act_r == ACT_EVICT) begin
            if (!bflag_r[tgt_r]) occ_r[tgt_r] <= 1'b0;
            del_r[tgt_r] <= 1'b1;
            if (live_r != '0) live_r <= live_r - 1'b1;
          end
          if (act_r == ACT_EVICT) begin
            evict_r <= evict_r + 1'b1;
            pos_r   <= cur_r.start;
            pcnt_r  <= '0;
            state_r <= S_FREE;
          end else if (act_r == ACT_RETIRE) begin
            state_r <= S_FIN;
          end else begin
            state_r <= S_PF1;
          end
        end
        S_PF1: state_r <= S_PF2;
        S_PF2: begin
          if (!front_ok) back_r <= LW'(tgt_r);
          front_r <= LW'(tgt_r);
          if (act_r == ACT_NEW) live_r <= live_r + 1'b1;
          state_r <= S_FIN;
        end
        S_EVCHK: begin
          if (live_r >= cap && !back_r[LW-1]) begin
            tgt_r   <= back_r[IW-1:0];
            act_r   <= ACT_EVICT;
            state_r <= S_DET;
          end else begin
            pos_r   <= cur_r.start;
            pcnt_r  <= '0;
            state_r <= S_FREE;
          end
        end
        S_FREE: begin
          if (!occ_r[pos_r]) begin
            occ_r[pos_r]   <= 1'b1;
            del_r[pos_r]   <= 1'b0;
            bflag_r[pos_r] <= 1'b0;
            zflag_r[pos_r] <= 1'b0;
            tgt_r          <= pos_r;
            act_r          <= ACT_NEW;
            state_r        <= S_PF1;
          end else if (last_probe) begin
            status_r <= lthc_pkg::ST_DROPPED;
            state_r  <= S_FIN;
          end else begin
            pos_r  <= pos_next;
            pcnt_r <= pcnt_r + 1'b1;
          end
        end
        S_REL2: begin
          if (val_q == cur_r.handle) begin
            bflag_r[cur_r.rslot] <= (bor_dec != '0);
            if (bor_dec == '0 && del_r[cur_r.rslot]) occ_r[cur_r.rslot] <= 1'b0;
          end else begin
            status_r <= lthc_pkg::ST_IGNORED;
          end
          state_r <= S_FIN;
        end
        S_FIN: begin
          if (!ov_r || out_ready) begin
            ov_r       <= 1'b1;
            o_status_r <= status_r;
            o_fval_r   <= fval_r;
            o_fslot_r  <= fslot_r;
            o_live_r   <= live_r;
            o_hit_r    <= hit_r;
            o_miss_r   <= miss_r;
            o_evict_r  <= evict_r;
            state_r    <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid          = ov_r;
  assign out_status         = o_status_r;
  assign out_found_value    = o_fval_r;
  assign out_found_slot     = o_fslot_r;
  assign out_live_count     = o_live_r;
  assign out_hit_total      = o_hit_r;
  assign out_miss_total     = o_miss_r;
  assign out_eviction_total = o_evict_r;

endmodule

>>> sv/lru_ttl_hash_cache_unit.sv
// ----------------------------------------------------------------------------
// lru_ttl_hash_cache_unit
// One shard of a key/value cache with linear probing, LRU replacement and an
// age limit, with an APB register port for capacity and time to live.
//
//   channel   direction   handshake             beat carries
//   in_*      input       in_valid/in_ready     func, key, handle, slot, time
//   out_*     output      out_valid/out_ready   status, value, slot, counters
//   p*        config      psel/penable, pready  capacity and ttl registers
//
// The front takes a beat, hashes one key byte a cycle and reduces the hash
// two bits a cycle. The back probes each slot in a read step and a compare
// step through the key memory read port, then unlinks and relinks the entry
// in the LRU list; a free-slot search for a new key takes one slot a cycle.
// Invalidate and clear go from the idle step straight to the final step.
// Reset is synchronous and needs no clearing pass. A two-entry queue lets
// the front accept while the back works or the output register waits.
// ----------------------------------------------------------------------------
module lru_ttl_hash_cache_unit (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [lthc_pkg::FUNC_W-1:0]        in_func,
  input  logic [lthc_pkg::KEY_W-1:0]         in_lookup_key,
  input  logic [lthc_pkg::VAL_W-1:0]         in_value_handle,
  input  logic [lthc_pkg::IDX_W-1:0]         in_release_slot,
  input  logic [lthc_pkg::TIME_BITS-1:0]     in_now_s,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [lthc_pkg::STAT_W-1:0]        out_status,
  output logic [lthc_pkg::VAL_W-1:0]         out_found_value,
  output logic [lthc_pkg::IDX_W-1:0]         out_found_slot,
  output logic [lthc_pkg::CAP_W-1:0]         out_live_count,
  output logic [lthc_pkg::CNT_W-1:0]         out_hit_total,
  output logic [lthc_pkg::CNT_W-1:0]         out_miss_total,
  output logic [lthc_pkg::CNT_W-1:0]         out_eviction_total,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [lthc_pkg::ADDR_W-1:0]        paddr,
  input  logic [lthc_pkg::DATA_W-1:0]        pwdata,
  output logic [lthc_pkg::DATA_W-1:0]        prdata,
  output logic                               pready
);

  logic [lthc_pkg::CAP_W-1:0] cap_r;
  logic [lthc_pkg::TTL_W-1:0] ttl_r;
  logic [lthc_pkg::CAP_W-1:0] cap_eff;
  logic                       reg_sel;
  logic                       q_push_valid;
  logic                       q_push_ready;
  lthc_pkg::item_t            q_push_item;
  logic                       q_pop_valid;
  logic                       q_pop_ready;
  lthc_pkg::item_t            q_pop_item;

  assign pready  = 1'b1;
  assign reg_sel = paddr[2];
  assign cap_eff = lthc_pkg::eff_cap(cap_r);

  always_comb begin
    unique case (reg_sel)
      lthc_pkg::REG_CAPACITY: prdata = lthc_pkg::DATA_W'(cap_r);
      lthc_pkg::REG_TTL:      prdata = lthc_pkg::DATA_W'(ttl_r);
      default:                prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= lthc_pkg::CAP_RESET;
      ttl_r <= lthc_pkg::TTL_RESET;
    end else if (psel && penable && pwrite && pready) begin
      unique case (reg_sel)
        lthc_pkg::REG_CAPACITY: cap_r <= pwdata[lthc_pkg::CAP_W-1:0];
        lthc_pkg::REG_TTL:      ttl_r <= pwdata[lthc_pkg::TTL_W-1:0];
        default: begin
        end
      endcase
    end
  end

  lthc_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_func         (in_func),
    .in_lookup_key   (in_lookup_key),
    .in_value_handle (in_value_handle),
    .in_release_slot (in_release_slot),
    .in_now_s        (in_now_s),
    .cap             (cap_eff),
    .q_valid         (q_push_valid),
    .q_ready         (q_push_ready),
    .q_item          (q_push_item)
  );

  lthc_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (q_push_valid),
    .push_ready (q_push_ready),
    .push_item  (q_push_item),
    .pop_valid  (q_pop_valid),
    .pop_ready  (q_pop_ready),
    .pop_item   (q_pop_item)
  );

  lthc_back u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .cap                (cap_eff),
    .ttl                (ttl_r),
    .q_valid            (q_pop_valid),
    .q_ready            (q_pop_ready),
    .q_item             (q_pop_item),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_status         (out_status),
    .out_found_value    (out_found_value),
    .out_found_slot     (out_found_slot),
    .out_live_count     (out_live_count),
    .out_hit_total      (out_hit_total),
    .out_miss_total     (out_miss_total),
    .out_eviction_total (out_eviction_total)
  );

endmodule

>>> sv/lthc_checker.sv
// ----------------------------------------------------------------------------
// lthc_checker
// Port-level checks of the cache result channel, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lthc_checker (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               out_valid,
  input  logic                               out_ready,
  input  logic [lthc_pkg::STAT_W-1:0]        out_status,
  input  logic [lthc_pkg::VAL_W-1:0]         out_found_value,
  input  logic [lthc_pkg::IDX_W-1:0]         out_found_slot,
  input  logic [lthc_pkg::CAP_W-1:0]         out_live_count
);

  // A waiting result beat holds its status.
  `ASSERT_IMPL(a_out_hold, clk, rst_n, out_valid && !out_ready, ##1 (out_valid && $stable(out_status)), "result beat dropped or changed while stalled")

  `ASSERT_IMPL(a_status_code, clk, rst_n, out_valid, out_status <= lthc_pkg::ST_IGNORED, "status code out of range")

  `ASSERT_IMPL(a_live_range, clk, rst_n, out_valid, out_live_count <= lthc_pkg::CAP_W'(lthc_pkg::ENTRIES), "live count above table size")

  // Only a get hit reports a value and a slot.
  `ASSERT_IMPL(a_no_value_on_fail, clk, rst_n, out_valid && out_status != lthc_pkg::ST_OK, out_found_value == '0 && out_found_slot == '0, "value or slot reported without a hit")

endmodule

bind lru_ttl_hash_cache_unit lthc_checker u_lthc_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_status      (out_status),
  .out_found_value (out_found_value),
  .out_found_slot  (out_found_slot),
  .out_live_count  (out_live_count)
);
